>>> src/spim_pkg.sv
// Package for the SPI master bit engine: field widths, register indexes,
// reset values and the result record shared by the core and the top level.
// No dependencies.
package spim_pkg;

    // Field widths fixed by the stream layout.
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int BIT_W    = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Default slot cap for a transaction.
    localparam int MAX_BYTES_DEF = 64;

    // Configuration register indexes.
    localparam logic CFG_TX_LENGTH = 1'b0;
    localparam logic CFG_RX_LENGTH = 1'b1;

    // Register reset values.
    localparam logic [LEN_W-1:0] TX_LENGTH_RST = 7'd1;
    localparam logic [LEN_W-1:0] RX_LENGTH_RST = 7'd2;
    localparam logic [BIT_W-1:0] BIT_FIRST     = 3'd7;
    localparam logic [BIT_W-1:0] BIT_LAST      = 3'd0;

    // One result record; csn_out lands in the lowest bit when packed.
    typedef struct packed {
        logic              done_res;
        logic              busy_res;
        logic [LEN_W-1:0]  byte_index;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              mosi_out;
        logic              sck_out;
        logic              csn_out;
    } spim_rslt_t;

endpackage

>>> src/spim_core.sv
// Transaction state and per-tick logic of the SPI master bit engine.
// Depends on spim_pkg; produces one result record for every tick stepped.
module spim_core
    import spim_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              start_req,
    input  logic              miso_in,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic [LEN_W-1:0]  tx_length,
    input  logic [LEN_W-1:0]  rx_length,
    output spim_rslt_t        rslt
);

    localparam int CMP_W = 9;

    logic              active_reg,  active_next;
    logic              phase_reg,   phase_next;
    logic [LEN_W-1:0]  slot_reg,    slot_next;
    logic [BIT_W-1:0]  bit_reg,     bit_next;
    logic [BYTE_W-1:0] tx_shift_reg, tx_shift_next;
    logic [BYTE_W-1:0] rx_shift_reg, rx_shift_next;
    logic              mosi_reg,    mosi_next;

    logic [LEN_W-1:0]  len_max;
    logic [LEN_W-1:0]  slot_total;
    logic [BYTE_W-1:0] tx_cur;

    // Slot total is the longer of the two lengths, capped at MAX_BYTES.
    always_comb begin
        len_max    = (tx_length > rx_length) ? tx_length : rx_length;
        slot_total = ({2'b00, len_max} > CMP_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : len_max;
        tx_cur     = (bit_reg == BIT_FIRST) ? tx_byte : tx_shift_reg;
    end

    // Next state and the result of this tick.
    always_comb begin
        active_next   = active_reg;
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        bit_next      = bit_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        mosi_next     = mosi_reg;
        rslt          = '0;
        rslt.csn_out    = 1'b1;
        rslt.byte_index = slot_reg;

        if (!active_reg) begin
            if (start_req) begin
                active_next     = 1'b1;
                phase_next      = 1'b0;
                slot_next       = '0;
                bit_next        = BIT_FIRST;
                rx_shift_next   = '0;
                rslt.byte_index = '0;
                rslt.csn_out    = 1'b0;
            end
        end else if (!phase_reg) begin
            // Low phase: drive MOSI, sample MISO, or finish the transaction.
            if (slot_reg >= slot_total) begin
                active_next   = 1'b0;
                rslt.done_res = 1'b1;
            end else begin
                rslt.csn_out  = 1'b0;
                tx_shift_next = tx_cur;
                if (slot_reg < tx_length) begin
                    mosi_next = tx_cur[bit_reg];
                end
                if (slot_reg < rx_length) begin
                    rx_shift_next = rx_shift_reg;
                    rx_shift_next[bit_reg] = rx_shift_reg[bit_reg] | miso_in;
                end
                phase_next = 1'b1;
            end
        end else begin
            // High phase: raise SCK, hand out a completed received byte, advance the bit and slot counters.
            rslt.csn_out = 1'b0;
            rslt.sck_out = 1'b1;
            if (bit_reg == BIT_LAST) begin
                if (slot_reg < rx_length) begin
                    rslt.rx_byte  = rx_shift_reg;
                    rslt.rx_valid = 1'b1;
                end
                rx_shift_next = '0;
                bit_next      = BIT_FIRST;
                slot_next     = slot_reg + 1'b1;
            end else begin
                bit_next = bit_reg - 1'b1;
            end
            phase_next = 1'b0;
        end

        rslt.mosi_out = mosi_next;
        rslt.busy_res = active_next;
    end

    // State registers, advanced once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            phase_reg    <= 1'b0;
            slot_reg     <= '0;
            bit_reg      <= BIT_FIRST;
            tx_shift_reg <= '0;
            rx_shift_reg <= '0;
            mosi_reg     <= 1'b0;
        end else if (step) begin
            active_reg   <= active_next;
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            bit_reg      <= bit_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            mosi_reg     <= mosi_next;
        end
    end

endmodule

>>> src/spi_master_bit_engine.sv
// Top level of the SPI master bit engine (mode 0, MSB first).
// Depends on spim_pkg and spim_core.
//
// Usage: every request on the s_ channel is one half-bit tick of the SPI
// clock and produces exactly one result request on the m_ channel carrying
// the pin levels (csn, sck, mosi) after that tick, a received byte when one
// completes, the slot index and the busy and done flags.
// A tick with start_req set while idle lowers chip select and begins a
// transaction of max(tx_length, rx_length) byte slots, capped at MAX_BYTES,
// each slot taking sixteen ticks; one more tick raises chip select.
// The result of a tick is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick per clock cycle; the single result register is the
// only stage, and a tick is taken whenever that register is empty or being
// drained in the same cycle.
// When the receiver stalls, the result register holds and s_tready drops
// until it is taken; no tick is lost.
// Reset (synchronous, aresetn low) returns to idle with tx_length 1 and
// rx_length 2. Lengths are to be written on the cfg_ port only while no
// transaction is running; the block itself does not enforce this.
module spi_master_bit_engine
    import spim_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Tick requests.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // start_req, miso_in, tx_byte[7:0], zero fill
    // Result requests.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // csn_out, sck_out, mosi_out, rx_byte[7:0],
                                           // rx_valid, byte_index[6:0], busy_res,
                                           // done_res, zero fill
    // Register writes.
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [LEN_W-1:0]    cfg_wdata
);

    logic [LEN_W-1:0] tx_length_reg;
    logic [LEN_W-1:0] rx_length_reg;
    logic             m_valid_reg;
    spim_rslt_t       rslt_reg;
    spim_rslt_t       rslt_next;
    logic             s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_length_reg <= TX_LENGTH_RST;
            rx_length_reg <= RX_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TX_LENGTH: tx_length_reg <= cfg_wdata;
                CFG_RX_LENGTH: rx_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    spim_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s_accept),
        .start_req (s_tdata[0]),
        .miso_in   (s_tdata[1]),
        .tx_byte   (s_tdata[9:2]),
        .tx_length (tx_length_reg),
        .rx_length (rx_length_reg),
        .rslt      (rslt_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rslt_reg <= rslt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - $bits(spim_rslt_t))'(0), rslt_reg};

    // An accepted tick always leaves a result behind.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted tick produced no result");

    // Done only comes with chip select raised and no transaction running.
    a_done_csn: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rslt_reg.done_res) |-> (rslt_reg.csn_out && !rslt_reg.busy_res))
        else $error("done without chip select raised");

    // A received byte completes only on a high phase.
    a_rx_on_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rslt_reg.rx_valid) |-> (rslt_reg.sck_out && !rslt_reg.csn_out))
        else $error("received byte outside a high phase");

    // Chip select is low whenever a transaction is running.
    a_busy_csn: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rslt_reg.busy_res) |-> !rslt_reg.csn_out)
        else $error("busy with chip select high");

endmodule

>>> tb/sv/spi_master_bit_engine_test.sv
// Self-checking testbench for the SPI master bit engine (mode 0, MSB first).
// Depends on spim_pkg and spi_master_bit_engine; a small class predicts the
// pin levels for every accepted tick and checks each result request.
module spi_master_bit_engine_test;
    import spim_pkg::*;

    // Predicts the pin state after each half-bit tick and keeps the results
    // still owed by the block, oldest first.
    class spi_pin_tracker;
        logic [LEN_W-1:0]  tx_len;
        logic [LEN_W-1:0]  rx_len;
        bit                active;
        bit                phase_hi;
        bit [LEN_W-1:0]    slot;
        bit [BIT_W-1:0]    bitn;
        bit [BYTE_W-1:0]   tx_sr;
        bit [BYTE_W-1:0]   rx_sr;
        bit                mosi;
        spim_rslt_t        pins_due[$];
        int                errors;

        function new();
            tx_len   = TX_LENGTH_RST;
            rx_len   = RX_LENGTH_RST;
            active   = 1'b0;
            phase_hi = 1'b0;
            slot     = '0;
            bitn     = BIT_FIRST;
            tx_sr    = '0;
            rx_sr    = '0;
            mosi     = 1'b0;
            errors   = 0;
        endfunction

        function void set_length(logic addr, logic [LEN_W-1:0] value);
            if (addr == CFG_TX_LENGTH) begin
                tx_len = value;
            end else begin
                rx_len = value;
            end
        endfunction

        // Works out the result of one accepted tick and queues it.
        function void note_tick(bit start, bit miso, bit [BYTE_W-1:0] txb);
            spim_rslt_t r;
            int         total;
            total = (tx_len > rx_len) ? tx_len : rx_len;
            if (total > MAX_BYTES_DEF) begin
                total = MAX_BYTES_DEF;
            end
            r = '0;
            r.csn_out = 1'b1;
            r.byte_index = slot;
            if (!active) begin
                if (start) begin
                    active = 1'b1;
                    phase_hi = 1'b0;
                    slot = '0;
                    bitn = BIT_FIRST;
                    rx_sr = '0;
                    r.byte_index = '0;
                    r.csn_out = 1'b0;
                end
            end else if (!phase_hi) begin
                // Low phase: either the last slot is behind us, or drive and sample.
                if (slot >= total) begin
                    active = 1'b0;
                    r.done_res = 1'b1;
                end else begin
                    r.csn_out = 1'b0;
                    if (bitn == BIT_FIRST) begin
                        tx_sr = txb;
                    end
                    if (slot < tx_len) begin
                        mosi = tx_sr[bitn];
                    end
                    if (slot < rx_len) begin
                        rx_sr[bitn] = rx_sr[bitn] | miso;
                    end
                    phase_hi = 1'b1;
                end
            end else begin
                // High phase: raise SCK and close the slot after its last bit.
                r.csn_out = 1'b0;
                r.sck_out = 1'b1;
                if (bitn == BIT_LAST) begin
                    if (slot < rx_len) begin
                        r.rx_byte = rx_sr;
                        r.rx_valid = 1'b1;
                    end
                    rx_sr = '0;
                    bitn = BIT_FIRST;
                    slot = slot + 1'b1;
                end else begin
                    bitn = bitn - 1'b1;
                end
                phase_hi = 1'b0;
            end
            r.mosi_out = mosi;
            r.busy_res = active;
            pins_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_pins(spim_rslt_t got);
            spim_rslt_t want;
            if (pins_due.size() == 0) begin
                $error("result request with nothing outstanding: %0h", got);
                errors++;
                return;
            end
            want = pins_due.pop_front();
            compare_field("csn_out", want.csn_out, got.csn_out);
            compare_field("sck_out", want.sck_out, got.sck_out);
            compare_field("mosi_out", want.mosi_out, got.mosi_out);
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("rx_valid", want.rx_valid, got.rx_valid);
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic                cfg_addr;
    logic [LEN_W-1:0]    cfg_wdata;

    spi_pin_tracker ticks;
    bit             tx_idle_on;
    bit             rx_idle_on;
    bit             hold_off_req;

    spi_master_bit_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous overall limit.
    initial begin
        #8000000;
        $display("spi_master_bit_engine verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every accepted result request against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ticks.check_pins(spim_rslt_t'(m_tdata[$bits(spim_rslt_t)-1:0]));
        end
    end

    // Offers one tick, with an optional gap first, and notes it once taken.
    task automatic send_tick(bit start, bit miso, bit [BYTE_W-1:0] txb);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, txb, miso, start};
        do @(posedge aclk); while (s_tready !== 1'b1);
        ticks.note_tick(start, miso, txb);
    endtask

    task automatic write_length(logic addr, logic [LEN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ticks.set_length(addr, value);
        @(posedge aclk);
    endtask

    // Clocks out the rest of a running transaction with random pin data.
    task automatic run_out_transfer();
        while (ticks.active) begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Stops offering ticks and waits until every result has been taken or a guard expires.
    task automatic drain_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (ticks.pins_due.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    initial begin
        bit [LEN_W-1:0] tx_sel;
        bit [LEN_W-1:0] rx_sel;
        bit             start;
        ticks = new();
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_off_req = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_TX_LENGTH;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset lengths: an idle tick, a start, then starts while busy.
        send_tick(1'b0, 1'b1, 8'hFF);
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b1, 8'hFF);
        send_tick(1'b1, 1'b0, 8'h5A);
        send_tick(1'b1, 1'b1, 8'h80);
        send_tick(1'b0, 1'b0, 8'h01);
        run_out_transfer();
        drain_results();

        // Both lengths zero: the transaction ends on the tick after start.
        write_length(CFG_TX_LENGTH, 7'd0);
        write_length(CFG_RX_LENGTH, 7'd0);
        send_tick(1'b1, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b0, 1'b1, 8'h7F);
        drain_results();

        // Small-length phases, random after the first two; phases 4 and 7 never idle.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    tx_sel = 7'd0;
                    rx_sel = 7'd3;
                end
                1: begin
                    tx_sel = 7'd2;
                    rx_sel = 7'd0;
                end
                5: begin
                    tx_sel = 7'($urandom_range(0, 8));
                    rx_sel = 7'($urandom_range(0, 8));
                end
                default: begin
                    tx_sel = 7'($urandom_range(0, 4));
                    rx_sel = 7'($urandom_range(0, 4));
                end
            endcase
            tx_idle_on = (p != 4 && p != 7);
            rx_idle_on = (p != 4 && p != 7);
            write_length(CFG_TX_LENGTH, tx_sel);
            write_length(CFG_RX_LENGTH, rx_sel);
            if (p == 2) begin
                hold_off_req = 1'b1;
            end
            for (int i = 0; i < 90; i++) begin
                start = ticks.active ? 1'($urandom_range(0, 1))
                                     : ($urandom_range(0, 9) < 7);
                send_tick(start, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            run_out_transfer();
            drain_results();
        end

        repeat (4) @(posedge aclk);
        if (ticks.pins_due.size() != 0) begin
            $error("%0d results never arrived", ticks.pins_due.size());
            ticks.errors++;
        end
        if (ticks.errors == 0) begin
            $display("spi_master_bit_engine verification clean");
        end else begin
            $display("spi_master_bit_engine verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/spim_pkg.sv
src/spim_core.sv
src/spi_master_bit_engine.sv
tb/sv/spi_master_bit_engine_test.sv
